[sv/pfde_pkg.sv]
// ----------------------------------------------------------------------------
// pfde_pkg - shared types and constants of the page frame buffer draw engine
// Command codes, sequencer states and store geometry.
// ----------------------------------------------------------------------------
package pfde_pkg;

  // Store geometry: one byte per column per page of eight rows.
  localparam int STORE_DEPTH  = 1024;
  localparam int STORE_IDX_W  = $clog2(STORE_DEPTH);
  localparam int PAGE_ROWS    = 8;
  localparam int PAGE_SHIFT   = $clog2(PAGE_ROWS);
  localparam int COORD_W      = 8;
  localparam int COUNT_W      = COORD_W + 1;
  localparam int OP_W         = 3;

  // Default frame size.
  localparam int FRAME_WIDTH_DEF  = 128;
  localparam int FRAME_HEIGHT_DEF = 64;

  // Stream payload widths (padded to whole bytes).
  localparam int IN_FIELDS_W = OP_W + 5 * COORD_W + STORE_IDX_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_SET_PIXEL   = 3'd0,
    OP_CLEAR_PIXEL = 3'd1,
    OP_HLINE       = 3'd2,
    OP_VLINE       = 3'd3,
    OP_OUTLINE     = 3'd4,
    OP_FILL        = 3'd5,
    OP_CLEAR_FRAME = 3'd6,
    OP_READ        = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEG,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_RD_ADDR,
    ST_RD_CAPT,
    ST_DONE
  } state_t;

endpackage

[sv/page_framebuffer_draw_engine_top.sv]
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_top - monochrome page-ordered frame draw engine
// Holds a FRAME_WIDTH x FRAME_HEIGHT one-bit frame in a 1024 x 8 store and
// executes pixel, line, rectangle, clear and read commands on it.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Ports                      | Payload
//  --------+-----------+----------------------------+---------------------------
//  in_     | slave     | in_tvalid/in_tready/tdata  | one draw or read command
//  out_    | master    | out_tvalid/out_tready/tdata| one result byte per command
//
//  Operation: pixel, line and rectangle commands run through one read-modify-write
//  unit on the store, a read state and a write state per on-frame pixel and a
//  single read state per skipped pixel; an outline sets up four segments and a
//  fill scans w x (h+1) pixels. A clear writes the 1024 store entries one per
//  cycle, and a read passes the address and capture states before done.
//  Reset: rst_n (synchronous, active low) starts a clearing pass that zeroes
//  all 1024 store entries; in_tready stays low until it ends.
//  Stalls: the result sits in an output register; the sequencer holds in its
//  final state only while a previous result has not been taken.
//
module page_framebuffer_draw_engine_top #(
  parameter int FRAME_WIDTH  = pfde_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = pfde_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata, from bit 0 up: op[3], x_first[8], y_first[8], x_second[8],
  // y_second[8], line_length[8], byte_index[10], zero pad[3]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pfde_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata, from bit 0 up: read_data[8]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pfde_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pfde_pkg::*;

  // Width of the pixel address before the store range check. Always wide
  // enough to hold STORE_DEPTH itself so the range compare is exact.
  localparam int SumRaw = $clog2(FRAME_WIDTH * (256 / PAGE_ROWS)) + 1;
  localparam int SumW   = (SumRaw > STORE_IDX_W + 1) ? SumRaw : STORE_IDX_W + 1;

  // --------------------------------------------------------------------------
  // Frame store: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic [7:0]             mem [STORE_DEPTH];
  logic                   mem_we;
  logic [STORE_IDX_W-1:0] mem_waddr;
  logic [7:0]             mem_wdata;
  logic [STORE_IDX_W-1:0] mem_raddr;
  logic [7:0]             mem_q_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                 state_r, state_nxt;
  logic                   boot_r, boot_nxt;
  logic [STORE_IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // Command fields, held for the whole command
  op_t                    op_r, op_nxt;
  logic [COORD_W-1:0]     xa_r, xa_nxt;
  logic [COORD_W-1:0]     ya_r, ya_nxt;
  logic [COORD_W-1:0]     xb_r, xb_nxt;
  logic [COORD_W-1:0]     yb_r, yb_nxt;
  logic [COORD_W-1:0]     len_r, len_nxt;
  logic [STORE_IDX_W-1:0] idx_r, idx_nxt;

  // Scan of the current segment: base corner, extent and position
  logic [1:0]             seg_r, seg_nxt;
  logic [COORD_W-1:0]     seg_x_r, seg_x_nxt;
  logic [COORD_W-1:0]     seg_y_r, seg_y_nxt;
  logic [COUNT_W-1:0]     ni_r, ni_nxt;
  logic [COUNT_W-1:0]     nj_r, nj_nxt;
  logic [COORD_W-1:0]     i_r, i_nxt;
  logic [COORD_W-1:0]     j_r, j_nxt;

  // Read-modify-write operands
  logic [STORE_IDX_W-1:0] pix_addr_r, pix_addr_nxt;
  logic [7:0]             bit_r, bit_nxt;
  logic [7:0]             rd_byte_r, rd_byte_nxt;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_data_r, out_data_nxt;

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic                   in_xfer;
  op_t                    in_op;
  logic                   clr_last;
  logic [COORD_W-1:0]     rect_w, rect_h;
  logic [COORD_W-1:0]     sp_x, sp_y;
  logic [COUNT_W-1:0]     sp_ni, sp_nj;
  logic                   seg_empty, seg_more;
  logic [COORD_W-1:0]     x_cur, y_cur;
  logic [SumW-1:0]        page_prod, pix_sum;
  logic                   pix_ok;
  logic                   i_last, j_last, pix_last;
  logic                   out_load;
  logic                   erase;

  assign in_op    = op_t'(in_tdata[OP_W-1:0]);
  assign in_xfer  = in_tvalid && in_tready;
  assign clr_last = (clr_cnt_r == STORE_IDX_W'(STORE_DEPTH - 1));
  assign rect_w   = xb_r - xa_r + COORD_W'(1);
  assign rect_h   = yb_r - ya_r;
  assign seg_more = (op_r == OP_OUTLINE) && (seg_r != 2'd3);
  assign erase    = (op_r == OP_CLEAR_PIXEL);

  // Segment table: every pixel, line and rectangle command is one or more rectangular scans
  always_comb begin
    sp_x  = xa_r;
    sp_y  = ya_r;
    sp_ni = COUNT_W'(1);
    sp_nj = COUNT_W'(1);
    case (op_r)
      OP_HLINE: sp_ni = {1'b0, len_r};
      OP_VLINE: sp_nj = {1'b0, len_r};
      OP_FILL: begin
        sp_ni = {1'b0, rect_w};
        sp_nj = {1'b0, rect_h} + COUNT_W'(1);
      end
      OP_OUTLINE: begin
        case (seg_r)
          2'd0: sp_ni = {1'b0, rect_w};
          2'd1: begin
            sp_y  = yb_r;
            sp_ni = {1'b0, rect_w};
          end
          2'd2: sp_nj = {1'b0, rect_h};
          default: begin
            sp_x  = xb_r;
            sp_nj = {1'b0, rect_h};
          end
        endcase
      end
      default: ;
    endcase
  end

  assign seg_empty = (sp_ni == '0) || (sp_nj == '0);

  // Pixel address unit: x + (y / 8) * FRAME_WIDTH with frame and store checks
  assign x_cur     = seg_x_r + i_r;
  assign y_cur     = seg_y_r + j_r;
  assign page_prod = SumW'(y_cur[COORD_W-1:PAGE_SHIFT]) * SumW'(FRAME_WIDTH);
  assign pix_sum   = SumW'(x_cur) + page_prod;
  assign pix_ok    = ({1'b0, x_cur} < COUNT_W'(FRAME_WIDTH))
                  && ({1'b0, y_cur} < COUNT_W'(FRAME_HEIGHT))
                  && (pix_sum < SumW'(STORE_DEPTH));

  assign j_last   = (({1'b0, j_r} + COUNT_W'(1)) == nj_r);
  assign i_last   = (({1'b0, i_r} + COUNT_W'(1)) == ni_r);
  assign pix_last = i_last && j_last;

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = boot_r ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_op)
            OP_CLEAR_FRAME: state_nxt = ST_CLEAR;
            OP_READ:        state_nxt = ST_RD_ADDR;
            default:        state_nxt = ST_SEG;
          endcase
        end
      end
      ST_SEG: begin
        if (!seg_empty) begin
          state_nxt = ST_PIX_RD;
        end else if (!seg_more) begin
          state_nxt = ST_DONE;
        end
      end
      ST_PIX_RD: begin
        if (pix_ok) begin
          state_nxt = ST_PIX_WR;
        end else if (pix_last) begin
          state_nxt = seg_more ? ST_SEG : ST_DONE;
        end
      end
      ST_PIX_WR: begin
        if (pix_last) begin
          state_nxt = seg_more ? ST_SEG : ST_DONE;
        end else begin
          state_nxt = ST_PIX_RD;
        end
      end
      ST_RD_ADDR: state_nxt = ST_RD_CAPT;
      ST_RD_CAPT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath next values
  // --------------------------------------------------------------------------
  always_comb begin
    boot_nxt      = boot_r;
    clr_cnt_nxt   = clr_cnt_r;
    op_nxt        = op_r;
    xa_nxt        = xa_r;
    ya_nxt        = ya_r;
    xb_nxt        = xb_r;
    yb_nxt        = yb_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    seg_nxt       = seg_r;
    seg_x_nxt     = seg_x_r;
    seg_y_nxt     = seg_y_r;
    ni_nxt        = ni_r;
    nj_nxt        = nj_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pix_addr_nxt  = pix_addr_r;
    bit_nxt       = bit_r;
    rd_byte_nxt   = rd_byte_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_CLEAR: begin
        // counter wraps back to zero after the last entry
        clr_cnt_nxt = clr_cnt_r + STORE_IDX_W'(1);
        if (clr_last) begin
          boot_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          op_nxt      = in_op;
          xa_nxt      = in_tdata[OP_W +: COORD_W];
          ya_nxt      = in_tdata[OP_W + COORD_W +: COORD_W];
          xb_nxt      = in_tdata[OP_W + 2*COORD_W +: COORD_W];
          yb_nxt      = in_tdata[OP_W + 3*COORD_W +: COORD_W];
          len_nxt     = in_tdata[OP_W + 4*COORD_W +: COORD_W];
          idx_nxt     = in_tdata[OP_W + 5*COORD_W +: STORE_IDX_W];
          seg_nxt     = 2'd0;
          rd_byte_nxt = 8'h00;
        end
      end
      ST_SEG: begin
        seg_x_nxt = sp_x;
        seg_y_nxt = sp_y;
        ni_nxt    = sp_ni;
        nj_nxt    = sp_nj;
        i_nxt     = '0;
        j_nxt     = '0;
        if (seg_empty && seg_more) begin
          seg_nxt = seg_r + 2'd1;
        end
      end
      ST_PIX_RD, ST_PIX_WR: begin
        pix_addr_nxt = pix_sum[STORE_IDX_W-1:0];
        bit_nxt      = 8'h01 << y_cur[PAGE_SHIFT-1:0];
        // advance the scan unless an on-frame pixel still needs its write
        if ((state_r == ST_PIX_WR) || !pix_ok) begin
          if (j_last) begin
            j_nxt = '0;
            i_nxt = i_r + COORD_W'(1);
          end else begin
            j_nxt = j_r + COORD_W'(1);
          end
          if (pix_last && seg_more) begin
            seg_nxt = seg_r + 2'd1;
          end
        end
      end
      ST_RD_CAPT: rd_byte_nxt = mem_q_r;
      default: ;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = rd_byte_r;
    end
  end

  // --------------------------------------------------------------------------
  // Outputs: store port controls and input ready
  // --------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pix_addr_r;
    mem_wdata = erase ? (mem_q_r & ~bit_r) : (mem_q_r | bit_r);
    mem_raddr = idx_r;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = 8'h00;
      end
      ST_IDLE:   in_tready = 1'b1;
      ST_PIX_RD: mem_raddr = pix_sum[STORE_IDX_W-1:0];
      ST_PIX_WR: mem_we    = 1'b1;
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      boot_r      <= 1'b1;
      clr_cnt_r   <= '0;
      seg_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    xa_r       <= xa_nxt;
    ya_r       <= ya_nxt;
    xb_r       <= xb_nxt;
    yb_r       <= yb_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    seg_x_r    <= seg_x_nxt;
    seg_y_r    <= seg_y_nxt;
    ni_r       <= ni_nxt;
    nj_r       <= nj_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    pix_addr_r <= pix_addr_nxt;
    bit_r      <= bit_nxt;
    rd_byte_r  <= rd_byte_nxt;
    out_data_r <= out_data_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("engine ready again right after taking a command");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done state");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PIX_WR) |-> $past(state_r == ST_PIX_RD))
    else $error("pixel write without its store read");

  a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (mem_we && (mem_wdata == 8'h00)))
    else $error("clearing pass not writing zero");

endmodule
